// File: rtl/core/mtcdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcdl_pkg
// Shared constants and types of the multi-tap circular delay line.
// ----------------------------------------------------------------------------
package mtcdl_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int TAP_COUNT   = 8;
    localparam int BLOCK_LEN   = 128;

    localparam int NUM_TAPS = 8;
    localparam int SMP_W    = 16;
    localparam int DLY_W    = 16;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int TAP_W    = $clog2(NUM_TAPS);
    localparam int CMP_W    = ((ADDR_W > DLY_W) ? ADDR_W : DLY_W) + 1;
    localparam int MAX_DLY  = (STORE_DEPTH > 2 * BLOCK_LEN) ?
                              (STORE_DEPTH - 2 * BLOCK_LEN) : 0;

    typedef logic signed [SMP_W-1:0] t_smp;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    typedef struct packed {
        logic                valid;
        logic                last;
        logic                keep;
        logic [TAP_W-1:0]    idx;
        logic [NUM_TAPS-1:0] mask;
    } t_rd_req;

endpackage

// File: rtl/core/mtcdl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcdl_in_if
// Sample input channel: valid, ready and one signed sample.
// ----------------------------------------------------------------------------
interface mtcdl_in_if;
    import mtcdl_pkg::*;

    logic valid;
    logic ready;
    t_smp sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// File: rtl/core/mtcdl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcdl_out_if
// Result channel: valid, ready, eight tap samples and the enable mask.
// ----------------------------------------------------------------------------
interface mtcdl_out_if;
    import mtcdl_pkg::*;

    logic                valid;
    logic                ready;
    t_smp                out_tap0;
    t_smp                out_tap1;
    t_smp                out_tap2;
    t_smp                out_tap3;
    t_smp                out_tap4;
    t_smp                out_tap5;
    t_smp                out_tap6;
    t_smp                out_tap7;
    logic [NUM_TAPS-1:0] tap_valid_mask;

    modport source (
        output valid, output out_tap0, output out_tap1, output out_tap2,
        output out_tap3, output out_tap4, output out_tap5, output out_tap6,
        output out_tap7, output tap_valid_mask, input ready
    );
    modport sink (
        input valid, input out_tap0, input out_tap1, input out_tap2,
        input out_tap3, input out_tap4, input out_tap5, input out_tap6,
        input out_tap7, input tap_valid_mask, output ready
    );
endinterface

// File: rtl/core/mtcdl_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcdl_store
// Single-port sample memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mtcdl_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [mtcdl_pkg::ADDR_W-1:0] i_addr,
    input  mtcdl_pkg::t_smp             i_wdata,
    output mtcdl_pkg::t_smp             o_rdata
);
    import mtcdl_pkg::*;

    t_smp r_mem [STORE_DEPTH];
    t_smp r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/mtcdl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcdl_ctrl
// Input buffer, write head and access sequencer: one write, then eight tap
// reads per sample.
// ----------------------------------------------------------------------------
module mtcdl_ctrl (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    mtcdl_in_if.sink                                       i_smp,
    input  logic [mtcdl_pkg::NUM_TAPS-1:0][mtcdl_pkg::DLY_W-1:0] i_tap_delay,
    input  logic                                           i_stall,
    output logic                                           o_mem_we,
    output logic [mtcdl_pkg::ADDR_W-1:0]                   o_mem_addr,
    output mtcdl_pkg::t_smp                                o_mem_wdata,
    output mtcdl_pkg::t_rd_req                             o_rd_req
);
    import mtcdl_pkg::*;

    t_state              r_state, n_state;
    logic [TAP_W-1:0]    r_tap, n_tap;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic                r_wrapped, n_wrapped;
    logic                r_buf_valid, n_buf_valid;
    t_smp                r_buf_sample;

    logic [DLY_W-1:0]    tap_reg;
    logic [DLY_W-1:0]    dly_m1;
    logic [CMP_W-1:0]    dly_ext;
    logic [CMP_W-1:0]    dly_sat;
    logic [ADDR_W-1:0]   dly;
    logic [ADDR_W:0]     rd_wrap;
    logic [ADDR_W-1:0]   rd_addr;
    logic                written;
    logic [NUM_TAPS-1:0] mask;
    logic                accept;
    logic                issue;

    assign accept      = i_smp.valid && !r_buf_valid;
    assign i_smp.ready = !r_buf_valid;

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            mask[k] = (k < TAP_COUNT) && (i_tap_delay[k] != '0);
        end
    end

    // read address of the current tap, wrapping below zero
    always_comb begin
        tap_reg = i_tap_delay[r_tap];
        dly_m1  = tap_reg - DLY_W'(1);
        dly_ext = CMP_W'(dly_m1);
        dly_sat = (dly_ext > CMP_W'(MAX_DLY)) ? CMP_W'(MAX_DLY) : dly_ext;
        dly     = dly_sat[ADDR_W-1:0];
        rd_wrap = {1'b0, r_head} + (ADDR_W + 1)'(STORE_DEPTH) - {1'b0, dly};
        if (dly <= r_head) begin
            rd_addr = r_head - dly;
        end else begin
            rd_addr = rd_wrap[ADDR_W-1:0];
        end
        // entries beyond the head are unwritten until the first wrap
        written = r_wrapped || (rd_addr <= r_head);
    end

    assign o_mem_we    = (r_state == S_IDLE) && r_buf_valid;
    assign issue       = (r_state == S_READ) && !((r_tap == '0) && i_stall);
    assign o_mem_addr  = o_mem_we ? r_head : rd_addr;
    assign o_mem_wdata = r_buf_sample;

    always_comb begin
        o_rd_req.valid = issue;
        o_rd_req.last  = (r_tap == TAP_W'(NUM_TAPS - 1));
        o_rd_req.keep  = mask[r_tap] && written;
        o_rd_req.idx   = r_tap;
        o_rd_req.mask  = mask;
    end

    always_comb begin
        n_state     = r_state;
        n_tap       = r_tap;
        n_head      = r_head;
        n_wrapped   = r_wrapped;
        n_buf_valid = r_buf_valid;
        if (accept) begin
            n_buf_valid = 1'b1;
        end else if (o_mem_we) begin
            n_buf_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (r_buf_valid) begin
                    n_state = S_READ;
                    n_tap   = '0;
                end
            end
            S_READ: begin
                if (issue) begin
                    n_tap = r_tap + TAP_W'(1);
                    if (r_tap == TAP_W'(NUM_TAPS - 1)) begin
                        n_state = S_IDLE;
                        if (r_head == ADDR_W'(STORE_DEPTH - 1)) begin
                            n_head    = '0;
                            n_wrapped = 1'b1;
                        end else begin
                            n_head = r_head + ADDR_W'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_head      <= '0;
            r_wrapped   <= 1'b0;
            r_buf_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tap       <= n_tap;
            r_head      <= n_head;
            r_wrapped   <= n_wrapped;
            r_buf_valid <= n_buf_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf_sample <= i_smp.sample_in;
        end
    end
endmodule

// File: rtl/core/mtcdl_gather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcdl_gather
// Collects the tap read data into a result and holds it in the output
// register until the transfer.
// ----------------------------------------------------------------------------
module mtcdl_gather (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtcdl_pkg::t_rd_req  i_rd_req,
    input  mtcdl_pkg::t_smp     i_rdata,
    output logic                o_stall,
    mtcdl_out_if.source         o_res
);
    import mtcdl_pkg::*;

    t_rd_req             r_req;
    t_smp                r_acc [NUM_TAPS];
    logic [NUM_TAPS-1:0] r_mask;
    logic                r_done, n_done;
    logic                r_out_valid, n_out_valid;
    t_smp                r_out [NUM_TAPS];
    logic [NUM_TAPS-1:0] r_out_mask;
    logic                move;

    assign move    = r_done && (!r_out_valid || o_res.ready);
    assign o_stall = r_done && !move;

    always_comb begin
        n_done = r_done;
        if (r_req.valid && r_req.last) begin
            n_done = 1'b1;
        end else if (move) begin
            n_done = 1'b0;
        end
        n_out_valid = move || (r_out_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req       <= i_rd_req;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req.valid) begin
            r_acc[r_req.idx] <= r_req.keep ? i_rdata : '0;
            if (r_req.idx == '0) begin
                r_mask <= r_req.mask;
            end
        end
        if (move) begin
            r_out      <= r_acc;
            r_out_mask <= r_mask;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_tap0       = r_out[0];
    assign o_res.out_tap1       = r_out[1];
    assign o_res.out_tap2       = r_out[2];
    assign o_res.out_tap3       = r_out[3];
    assign o_res.out_tap4       = r_out[4];
    assign o_res.out_tap5       = r_out[5];
    assign o_res.out_tap6       = r_out[6];
    assign o_res.out_tap7       = r_out[7];
    assign o_res.tap_valid_mask = r_out_mask;
endmodule

// File: rtl/core/multi_tap_circular_delay_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_tap_circular_delay_line
// Eight-tap delay line over a circular sample store in one single-port
// memory. Each sample is written at the head, then every tap is read back.
// Result path: input buffer, memory write, tap reads, gather, then the
// output register when it is free; a result held by back-pressure delays
// the next sample's tap reads.
// Throughput is set by the single memory port (one write plus eight tap
// reads per sample); the next sample can be buffered during the tap reads.
// Reset: tap registers and write head clear; the store itself is not swept,
// entries not yet written since reset read as zero through a wrap flag.
// ----------------------------------------------------------------------------
module multi_tap_circular_delay_line (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mtcdl_in_if.sink                     i_smp,
    mtcdl_out_if.source                  o_res,
    input  logic                         i_cfg_we,
    input  logic [mtcdl_pkg::TAP_W-1:0]  i_cfg_idx,
    input  logic [mtcdl_pkg::DLY_W-1:0]  i_cfg_data
);
    import mtcdl_pkg::*;

    logic [NUM_TAPS-1:0][DLY_W-1:0] r_tap_delay;

    logic              w_stall;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_addr;
    t_smp              w_mem_wdata;
    t_smp              w_mem_rdata;
    t_rd_req           w_rd_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_delay <= '0;
        end else if (i_cfg_we) begin
            r_tap_delay[i_cfg_idx] <= i_cfg_data;
        end
    end

    mtcdl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (i_smp),
        .i_tap_delay (r_tap_delay),
        .i_stall     (w_stall),
        .o_mem_we    (w_mem_we),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .o_rd_req    (w_rd_req)
    );

    mtcdl_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    mtcdl_gather u_gather (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_req (w_rd_req),
        .i_rdata  (w_mem_rdata),
        .o_stall  (w_stall),
        .o_res    (o_res)
    );

    // one memory access per cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_req.valid |-> !w_mem_we)
        else $error("write and tap read in the same cycle");

    // every write is followed by tap reads before the next write
    a_no_double_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> !w_mem_we)
        else $error("two sample writes back to back");

    // input buffer holds the transferred sample
    a_buf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("input buffer not held after transfer");

    // disabled taps read as zero
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |->
            ((o_res.tap_valid_mask[0] || o_res.out_tap0 == '0) &&
             (o_res.tap_valid_mask[1] || o_res.out_tap1 == '0) &&
             (o_res.tap_valid_mask[2] || o_res.out_tap2 == '0) &&
             (o_res.tap_valid_mask[3] || o_res.out_tap3 == '0) &&
             (o_res.tap_valid_mask[4] || o_res.out_tap4 == '0) &&
             (o_res.tap_valid_mask[5] || o_res.out_tap5 == '0) &&
             (o_res.tap_valid_mask[6] || o_res.out_tap6 == '0) &&
             (o_res.tap_valid_mask[7] || o_res.out_tap7 == '0)))
        else $error("disabled tap with nonzero sample");
endmodule
